// File: hdl/svfa_pkg.sv
// Shared types, constants and the microcode program of the voice filter and amplifier.
// Depends on nothing; the datapath, the top level and the testbench refer to it by scoped names.
package svfa_pkg;

  // Fixed-point widths of the shared multiply-accumulate datapath.
  localparam int A_W   = 17;   // operand A: stores, clipped mix, or their difference
  localparam int B_W   = 9;    // operand B: a coefficient, signed or zero-extended
  localparam int P_W   = A_W + B_W;
  localparam int ACC_W = 28;
  localparam int Q_SH  = 7;    // every product sum is taken down by this many bits
  localparam int SH_W  = ACC_W - Q_SH;

  localparam logic signed [SH_W-1:0] CLIP_HI = SH_W'(127);
  localparam logic signed [SH_W-1:0] CLIP_LO = -SH_W'(127);
  localparam logic [7:0]             PWM_OFS = 8'd127;
  localparam logic [6:0]             HPF_ONE = 7'd127;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HPF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd4;

  // Filter modes; every other code runs the bypass path.
  localparam logic [1:0] MODE_RESONANT = 2'd1;
  localparam logic [1:0] MODE_TWOSTAGE = 2'd2;

  // Microcode program addresses.
  localparam int UPC_W = 5;
  localparam logic [UPC_W-1:0] UA_DISPATCH = 5'd0;
  localparam logic [UPC_W-1:0] UA_RESONANT = 5'd1;
  localparam logic [UPC_W-1:0] UA_TWOSTAGE = 5'd9;
  localparam logic [UPC_W-1:0] UA_BYPASS   = 5'd16;
  localparam logic [UPC_W-1:0] UA_HIPASS   = 5'd17;

  typedef enum logic [2:0] {
    A_X, A_S1, A_S2, A_HP, A_DIFF
  } a_sel_e;

  typedef enum logic [2:0] {
    B_CUT, B_FB, B_HPF, B_HPF_CMP, B_GAIN
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_e;

  typedef enum logic [2:0] {
    WB_NONE, WB_S1_ADD, WB_S1_SUB, WB_S2_ADD, WB_S2_SUB, WB_S2_X, WB_HP, WB_OUT
  } wb_e;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_MODE, JMP_GOTO, JMP_DONE
  } jump_e;

  // One control word. The accumulate operation works on the product issued by the
  // previous word; a write-back sees the accumulator value formed in the same step.
  typedef struct packed {
    logic             mul_en;
    a_sel_e           a_sel;
    b_sel_e           b_sel;
    acc_op_e          acc_op;
    wb_e              wb;
    jump_e            jump;
    logic [UPC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic signed [7:0] cutoff;
    logic signed [7:0] feedback;
    logic [6:0]        hpf;
    logic [7:0]        gain;
  } cfg_t;

  typedef struct packed {
    ucode_t uc;
    logic   step_en;
    logic   load_x;
    logic   clr_filt;
  } dp_ctrl_t;

  function automatic ucode_t uc_word(logic mul_en, a_sel_e a_sel, b_sel_e b_sel,
                                     acc_op_e acc_op, wb_e wb, jump_e jump,
                                     logic [UPC_W-1:0] target);
    ucode_t w;
    w.mul_en = mul_en;
    w.a_sel  = a_sel;
    w.b_sel  = b_sel;
    w.acc_op = acc_op;
    w.wb     = wb;
    w.jump   = jump;
    w.target = target;
    return w;
  endfunction

  // The program. Resonant lowpass:
  //   s1 += (x*c - s1*c + s1*r - s2*r) >> 7,  s2 += (s1*c - s2*c) >> 7.
  // Two-stage filter:
  //   s1 -= (s1*r - s2*c + x*c) >> 7,         s2 -= (s2*r + s1*c) >> 7.
  // Both, and the bypass path, then share the highpass and gain tail.
  function automatic ucode_t ucode_rom(logic [UPC_W-1:0] upc);
    ucode_t w;
    case (upc)
      5'd0:  w = uc_word(1'b0, A_X,    B_CUT,     ACC_HOLD, WB_NONE,   JMP_MODE, UA_DISPATCH);
      5'd1:  w = uc_word(1'b1, A_X,    B_CUT,     ACC_HOLD, WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd2:  w = uc_word(1'b1, A_S1,   B_CUT,     ACC_LOAD, WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd3:  w = uc_word(1'b1, A_S1,   B_FB,      ACC_SUB,  WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd4:  w = uc_word(1'b1, A_S2,   B_FB,      ACC_ADD,  WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd5:  w = uc_word(1'b0, A_X,    B_CUT,     ACC_SUB,  WB_S1_ADD, JMP_NEXT, UA_DISPATCH);
      5'd6:  w = uc_word(1'b1, A_S1,   B_CUT,     ACC_HOLD, WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd7:  w = uc_word(1'b1, A_S2,   B_CUT,     ACC_LOAD, WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd8:  w = uc_word(1'b0, A_X,    B_CUT,     ACC_SUB,  WB_S2_ADD, JMP_GOTO, UA_HIPASS);
      5'd9:  w = uc_word(1'b1, A_S1,   B_FB,      ACC_HOLD, WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd10: w = uc_word(1'b1, A_S2,   B_CUT,     ACC_LOAD, WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd11: w = uc_word(1'b1, A_X,    B_CUT,     ACC_SUB,  WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd12: w = uc_word(1'b0, A_X,    B_CUT,     ACC_ADD,  WB_S1_SUB, JMP_NEXT, UA_DISPATCH);
      5'd13: w = uc_word(1'b1, A_S2,   B_FB,      ACC_HOLD, WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd14: w = uc_word(1'b1, A_S1,   B_CUT,     ACC_LOAD, WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd15: w = uc_word(1'b0, A_X,    B_CUT,     ACC_ADD,  WB_S2_SUB, JMP_GOTO, UA_HIPASS);
      5'd16: w = uc_word(1'b0, A_X,    B_CUT,     ACC_HOLD, WB_S2_X,   JMP_GOTO, UA_HIPASS);
      5'd17: w = uc_word(1'b1, A_S2,   B_HPF,     ACC_HOLD, WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd18: w = uc_word(1'b1, A_HP,   B_HPF_CMP, ACC_LOAD, WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd19: w = uc_word(1'b0, A_X,    B_CUT,     ACC_ADD,  WB_HP,     JMP_NEXT, UA_DISPATCH);
      5'd20: w = uc_word(1'b1, A_DIFF, B_GAIN,    ACC_HOLD, WB_NONE,   JMP_NEXT, UA_DISPATCH);
      5'd21: w = uc_word(1'b0, A_X,    B_CUT,     ACC_LOAD, WB_OUT,    JMP_DONE, UA_DISPATCH);
      default: w = uc_word(1'b0, A_X,  B_CUT,     ACC_HOLD, WB_NONE,   JMP_DONE, UA_DISPATCH);
    endcase
    return w;
  endfunction

  // Saturates a shifted accumulator value to -127..127.
  function automatic logic signed [7:0] clip127(logic signed [SH_W-1:0] v);
    logic signed [7:0] r;
    if (v > CLIP_HI) begin
      r = 8'sd127;
    end else if (v < CLIP_LO) begin
      r = -8'sd127;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/svfa_datapath.sv
// Datapath of the voice filter and amplifier: one shared multiplier, an accumulator,
// the filter and highpass stores and the output level register. Uses svfa_pkg.
module svfa_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  svfa_pkg::dp_ctrl_t    ctrl_i,
  input  svfa_pkg::cfg_t        cfg_i,
  input  logic signed [9:0]     mix_sum_i,
  output logic [7:0]            pwm_level_o
);

  logic signed [7:0]                       x_q;
  logic signed [15:0]                      s1_q, s1_d;
  logic signed [7:0]                       s2_q, s2_d;
  logic signed [15:0]                      hp_q, hp_d;
  logic signed [svfa_pkg::P_W-1:0]         prod_q;
  logic signed [svfa_pkg::ACC_W-1:0]       acc_q, acc_d;
  logic [7:0]                              pwm_q, pwm_d;

  logic signed [8:0]                       half;
  logic signed [7:0]                       x_d;
  logic signed [svfa_pkg::A_W-1:0]         op_a, diff;
  logic signed [svfa_pkg::B_W-1:0]         op_b;
  logic signed [svfa_pkg::P_W-1:0]         prod;
  logic signed [svfa_pkg::SH_W-1:0]        sh;
  logic signed [15:0]                      s2_wide, s2_sum;
  logic signed [7:0]                       y;

  // Halve with floor, then clip the mix.
  assign half = mix_sum_i[9:1];
  assign x_d  = svfa_pkg::clip127({{(svfa_pkg::SH_W - 9){half[8]}}, half});

  assign diff = {{9{s2_q[7]}}, s2_q} - {hp_q[15], hp_q};

  always_comb begin
    case (ctrl_i.uc.a_sel)
      svfa_pkg::A_X:    op_a = {{9{x_q[7]}}, x_q};
      svfa_pkg::A_S1:   op_a = {s1_q[15], s1_q};
      svfa_pkg::A_S2:   op_a = {{9{s2_q[7]}}, s2_q};
      svfa_pkg::A_HP:   op_a = {hp_q[15], hp_q};
      svfa_pkg::A_DIFF: op_a = diff;
      default:          op_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl_i.uc.b_sel)
      svfa_pkg::B_CUT:     op_b = {cfg_i.cutoff[7], cfg_i.cutoff};
      svfa_pkg::B_FB:      op_b = {cfg_i.feedback[7], cfg_i.feedback};
      svfa_pkg::B_HPF:     op_b = {2'b00, cfg_i.hpf};
      svfa_pkg::B_HPF_CMP: op_b = {2'b00, svfa_pkg::HPF_ONE - cfg_i.hpf};
      svfa_pkg::B_GAIN:    op_b = {1'b0, cfg_i.gain};
      default:             op_b = '0;
    endcase
  end

  assign prod = op_a * op_b;

  always_comb begin
    case (ctrl_i.uc.acc_op)
      svfa_pkg::ACC_LOAD: acc_d = {{2{prod_q[svfa_pkg::P_W-1]}}, prod_q};
      svfa_pkg::ACC_ADD:  acc_d = acc_q + {{2{prod_q[svfa_pkg::P_W-1]}}, prod_q};
      svfa_pkg::ACC_SUB:  acc_d = acc_q - {{2{prod_q[svfa_pkg::P_W-1]}}, prod_q};
      default:            acc_d = acc_q;
    endcase
  end

  // Floor shift by the Q7 scale; the stores take only its low 16 bits, and s2 is then clipped.
  assign sh      = acc_d[svfa_pkg::ACC_W-1:svfa_pkg::Q_SH];
  assign s2_wide = {{8{s2_q[7]}}, s2_q};
  assign s2_sum  = (ctrl_i.uc.wb == svfa_pkg::WB_S2_SUB) ? s2_wide - sh[15:0]
                                                         : s2_wide + sh[15:0];
  assign y       = svfa_pkg::clip127(sh);

  always_comb begin
    s1_d  = s1_q;
    s2_d  = s2_q;
    hp_d  = hp_q;
    pwm_d = pwm_q;
    case (ctrl_i.uc.wb)
      svfa_pkg::WB_S1_ADD: s1_d = s1_q + sh[15:0];
      svfa_pkg::WB_S1_SUB: s1_d = s1_q - sh[15:0];
      svfa_pkg::WB_S2_ADD,
      svfa_pkg::WB_S2_SUB: s2_d = svfa_pkg::clip127({{(svfa_pkg::SH_W - 16){s2_sum[15]}},
                                                     s2_sum});
      svfa_pkg::WB_S2_X:   s2_d = x_q;
      svfa_pkg::WB_HP:     hp_d = sh[15:0];
      svfa_pkg::WB_OUT:    pwm_d = y + svfa_pkg::PWM_OFS;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      hp_q <= '0;
    end else if (ctrl_i.clr_filt) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (ctrl_i.step_en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      hp_q <= hp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_x) begin
      x_q <= x_d;
    end
    if (ctrl_i.step_en && ctrl_i.uc.mul_en) begin
      prod_q <= prod;
    end
    if (ctrl_i.step_en) begin
      acc_q <= acc_d;
      pwm_q <= pwm_d;
    end
  end

  assign pwm_level_o = pwm_q;

endmodule

// File: hdl/synth_voice_filter_amp.sv
// Top level of the voice filter and amplifier: microcode sequencer, configuration
// registers and output handshake. Uses svfa_pkg and svfa_datapath.
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_stall_o    mix_sum_i
//   output    out        out_valid_o / out_stall_i  pwm_level_o
//   config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// After a request is accepted the sequencer runs the dispatch step, the program of the mode
// and the shared highpass and gain tail; the next request is taken only once it is idle again.
// The single shared multiplier, one product per cycle while no step is held, sets each pass's length.
// Reset clears the configuration, the filter and highpass stores and the sequencer.
// A result waits in the output register while the next request is being worked on;
// only the final step holds while the previous result is still stalled.
module synth_voice_filter_amp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [9:0]                    mix_sum_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [7:0]                           pwm_level_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [svfa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [7:0]                           cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_e;

  seq_state_e                   state_q, state_d;
  logic [svfa_pkg::UPC_W-1:0]   upc_q, upc_d;
  logic [svfa_pkg::UPC_W-1:0]   mode_target;
  logic                         out_valid_q, out_valid_d;

  logic [1:0]                   mode_q;
  svfa_pkg::cfg_t               cfg_q;

  svfa_pkg::ucode_t             uc;
  svfa_pkg::dp_ctrl_t           dp_ctrl;
  logic                         in_accept;
  logic                         cfg_we;
  logic                         out_hold;
  logic                         step_en;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // The control word for the current step comes straight from the program table.
  assign uc = svfa_pkg::ucode_rom(upc_q);

  // The output write waits until the previous result has left the output register.
  assign out_hold = (uc.wb == svfa_pkg::WB_OUT) && out_valid_q && out_stall_i;
  assign step_en  = (state_q == ST_RUN) && !out_hold;

  // The dispatch step jumps to the program of the selected filter mode.
  always_comb begin
    case (mode_q)
      svfa_pkg::MODE_RESONANT: mode_target = svfa_pkg::UA_RESONANT;
      svfa_pkg::MODE_TWOSTAGE: mode_target = svfa_pkg::UA_TWOSTAGE;
      default:                 mode_target = svfa_pkg::UA_BYPASS;
    endcase
  end

  always_comb begin
    state_d = state_q;
    upc_d   = upc_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_RUN;
          upc_d   = svfa_pkg::UA_DISPATCH;
        end
      end
      ST_RUN: begin
        if (step_en) begin
          case (uc.jump)
            svfa_pkg::JMP_NEXT: upc_d = upc_q + 1'b1;
            svfa_pkg::JMP_MODE: upc_d = mode_target;
            svfa_pkg::JMP_GOTO: upc_d = uc.target;
            svfa_pkg::JMP_DONE: begin
              state_d = ST_IDLE;
              upc_d   = svfa_pkg::UA_DISPATCH;
            end
            default: upc_d = svfa_pkg::UA_DISPATCH;
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
        upc_d   = svfa_pkg::UA_DISPATCH;
      end
    endcase
  end

  // Output register valid: set by the final step, cleared when the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step_en && (uc.wb == svfa_pkg::WB_OUT)) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      upc_q       <= svfa_pkg::UA_DISPATCH;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers. Writes to indexes past the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      cfg_q  <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        svfa_pkg::CFG_MODE:     mode_q         <= cfg_data_i[1:0];
        svfa_pkg::CFG_CUTOFF:   cfg_q.cutoff   <= cfg_data_i;
        svfa_pkg::CFG_FEEDBACK: cfg_q.feedback <= cfg_data_i;
        svfa_pkg::CFG_HPF:      cfg_q.hpf      <= cfg_data_i[6:0];
        svfa_pkg::CFG_GAIN:     cfg_q.gain     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Switching to a different filter mode starts both filter stores from zero.
  assign dp_ctrl.uc       = uc;
  assign dp_ctrl.step_en  = step_en;
  assign dp_ctrl.load_x   = in_accept;
  assign dp_ctrl.clr_filt = cfg_we && (cfg_index_i == svfa_pkg::CFG_MODE) &&
                            (cfg_data_i[1:0] != mode_q);

  svfa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (dp_ctrl),
    .cfg_i       (cfg_q),
    .mix_sum_i   (mix_sum_i),
    .pwm_level_o (pwm_level_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/svfa_checker.sv
// Port-level checks of the voice filter and amplifier, bound to the top level.
// Depends on synth_voice_filter_amp only through its ports.
module svfa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] pwm_level_o
);

  // A held result keeps its level until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pwm_level_o))
    else $error("stalled result changed or dropped");

  // The level never leaves the clipped range plus offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pwm_level_o <= 8'd254)
    else $error("level out of range");

  // One request at a time: the input side stalls right after a request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  // When a request finishes, its result is waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("request finished without a result");

endmodule

bind synth_voice_filter_amp svfa_checker u_svfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pwm_level_o (pwm_level_o)
);

// File: tb/sv/tb.sv
// Self-checking testbench for synth_voice_filter_amp: a short stimulus table, then random phases.
// Each phase loads new filter and gain settings and streams mix samples at random pacing.
// Depends on svfa_pkg and the synth_voice_filter_amp RTL only.
`timescale 1ns / 100ps

module tb;

  // Filter mode codes that the package leaves unnamed. Both of them run the bypass path.
  localparam logic [1:0] MODE_BYPASS = 2'd0;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  // Register indexes past the last register. The block ignores writes to them.
  localparam logic [svfa_pkg::CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam logic [svfa_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 3'd7;

  localparam int RANDOM_ITEMS   = 1850;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int SETTLE_CYCLES  = 30;    // longer than the longest sequencer pass

  // ---------------------------------------------------------------------------------------
  // Clock, reset and the ports of the block. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------------------
  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  logic signed [9:0]              mix_sum_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [7:0]                     pwm_level_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [svfa_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0]                     cfg_data_i  = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  synth_voice_filter_amp uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mix_sum_i   (mix_sum_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pwm_level_o (pwm_level_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------------------
  // Predictor. It keeps its own copy of the registers and of the three 16-bit stores and
  // works out the PWM level for every accepted mix sample. All products are formed in
  // 32-bit integers, which is wide enough for a full 16-bit store times a Q7 coefficient.
  // ---------------------------------------------------------------------------------------
  logic [1:0]         mode_q     = MODE_BYPASS;
  logic signed [7:0]  cutoff_q   = '0;
  logic signed [7:0]  feedback_q = '0;
  logic [6:0]         hpf_q      = '0;
  logic [7:0]         gain_q     = '0;
  logic signed [15:0] stage_one  = '0;
  logic signed [15:0] stage_two  = '0;
  logic signed [15:0] hp_state   = '0;

  // The first-stage and highpass stores wrap around rather than saturate.
  function automatic int wrap16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return t;
  endfunction

  function automatic int clip_sym(int v);
    if (v > 127) return 127;
    if (v < -127) return -127;
    return v;
  endfunction

  function automatic logic [7:0] predict_pwm_level(logic signed [9:0] mix);
    int x, c, r, s1, s2, h, hp, y;
    // Halving is a floor shift, so odd negative sums round toward minus infinity.
    x  = clip_sym(int'(mix) >>> 1);
    c  = cutoff_q;
    r  = feedback_q;
    s1 = stage_one;
    s2 = stage_two;
    h  = int'(hpf_q);
    hp = hp_state;
    if (mode_q == svfa_pkg::MODE_RESONANT) begin
      s1 = wrap16(s1 + ((x * c - s1 * c + s1 * r - s2 * r) >>> svfa_pkg::Q_SH));
      s2 = wrap16(s2 + ((s1 * c - s2 * c) >>> svfa_pkg::Q_SH));
    end else if (mode_q == svfa_pkg::MODE_TWOSTAGE) begin
      s1 = wrap16(s1 - ((s1 * r - s2 * c + x * c) >>> svfa_pkg::Q_SH));
      s2 = wrap16(s2 - ((s2 * r + s1 * c) >>> svfa_pkg::Q_SH));
    end else begin
      // Bypass and the spare mode code both pass the clipped mix straight through.
      s2 = x;
    end
    s2 = clip_sym(s2);
    stage_one = s1[15:0];
    stage_two = s2[15:0];
    // One-pole lowpass of the filter output, subtracted below to form the highpass.
    hp = wrap16((s2 * h + hp * (127 - h)) >>> svfa_pkg::Q_SH);
    hp_state = hp[15:0];
    y = clip_sym(((s2 - hp) * int'(gain_q)) >>> svfa_pkg::Q_SH);
    return 8'(y + 127);
  endfunction

  // A mode write clears both filter stores only when the mode actually changes. The
  // highpass store is left alone. Writes past the last register do nothing.
  function automatic void apply_reg_write(logic [svfa_pkg::CFG_IDX_W-1:0] idx,
                                          logic [7:0] data);
    case (idx)
      svfa_pkg::CFG_MODE: begin
        if (data[1:0] != mode_q) begin
          mode_q    = data[1:0];
          stage_one = '0;
          stage_two = '0;
        end
      end
      svfa_pkg::CFG_CUTOFF:   cutoff_q   = data;
      svfa_pkg::CFG_FEEDBACK: feedback_q = data;
      svfa_pkg::CFG_HPF:      hpf_q      = data[6:0];
      svfa_pkg::CFG_GAIN:     gain_q     = data;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, where the values seen are those
  // from before the edge, since the block and the drivers update only in the NBA region.
  // A result is checked before the request of the same edge is queued; it always belongs
  // to an older request.
  // ---------------------------------------------------------------------------------------
  logic [7:0] pending_levels [$];
  logic       pin_en    = 1'b0;   // the request on the port carries a hand-typed level
  logic [7:0] pin_level = '0;
  int         n_sent    = 0;
  int         n_checked = 0;
  int         n_errors  = 0;

  always @(posedge clk_i) begin
    logic [7:0] want;
    logic [7:0] predicted;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_levels.size() == 0) begin
          $display("%0t: pwm_level %0d arrived with no request pending", $time, pwm_level_o);
          n_errors++;
        end else begin
          want = pending_levels.pop_front();
          if (pwm_level_o !== want) begin
            $display("%0t: pwm_level mismatch, expected %0d, actual %0d",
                     $time, want, pwm_level_o);
            n_errors++;
          end
          n_checked++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        // The predictor runs for pinned rows too, so its stores stay in step.
        predicted = predict_pwm_level(mix_sum_i);
        pending_levels.push_back(pin_en ? pin_level : predicted);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        apply_reg_write(cfg_index_i, cfg_data_i);
      end
    end
  end

  // Watchdog: ends the run if no channel completes a handshake for too long.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_levels.size());
        $display("tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output stall. The stall rate changes from segment to segment (none, light, medium,
  // heavy), and once in a while the receiver holds off for a long burst.
  // ---------------------------------------------------------------------------------------
  int stall_pct        = 0;
  int stall_seg_left   = 0;
  int stall_burst_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_seg_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        stall_seg_left = $urandom_range(50, 400);
      end else begin
        stall_seg_left--;
      end
      if (stall_burst_left != 0) begin
        out_stall_i <= 1'b1;
        stall_burst_left--;
      end else if ($urandom_range(0, 499) == 0) begin
        out_stall_i <= 1'b1;
        stall_burst_left = $urandom_range(20, 80);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Request side. A valid stays high from one request to the next when no gap falls
  // between them; it is lowered only by a gap or by a wait for the block to drain.
  // ---------------------------------------------------------------------------------------
  bit feeding = 1'b0;  // samples have gone out since the last drain

  task automatic send_mix(input logic signed [9:0] mix, input logic pinned,
                          input logic [7:0] level);
    cfg_valid_i <= 1'b0;
    in_valid_i  <= 1'b1;
    mix_sum_i   <= mix;
    pin_en      <= pinned;
    pin_level   <= level;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    n_sent++;
    feeding = 1'b1;
  endtask

  task automatic write_reg(input logic [svfa_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
  endtask

  task automatic hold_off(input int cycles);
    cfg_valid_i <= 1'b0;
    in_valid_i  <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stops sending and waits until every result has come back.
  task automatic quiesce();
    cfg_valid_i <= 1'b0;
    in_valid_i  <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (n_checked != n_sent);
    feeding = 1'b0;
  endtask

  // Random values, with the extremes drawn often enough to matter.
  function automatic logic signed [9:0] pick_mix();
    case ($urandom_range(0, 15))
      0: return -10'sd512;
      1: return 10'sd511;
      2: return -10'sd381;
      3: return 10'sd381;
      4: return 10'($urandom);
      5: return 10'($urandom);
      default: return 10'(int'($urandom_range(0, 762)) - 381);
    endcase
  endfunction

  function automatic logic [7:0] pick_coeff();
    case ($urandom_range(0, 9))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return 8'hFF;
      4, 5, 6: return 8'($urandom_range(8, 120));  // the musically useful region
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_hpf();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd128;
      2: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // New settings for a random phase. The mode is always written, with random upper bits
  // in the data byte; sometimes it is written a second time with the same code, which
  // must leave the filter stores alone.
  task automatic retune();
    logic [7:0] mode_byte;
    mode_byte = 8'($urandom);
    write_reg(svfa_pkg::CFG_MODE, mode_byte);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(svfa_pkg::CFG_MODE, {6'($urandom), mode_byte[1:0]});
    end
    if ($urandom_range(0, 3) != 0) write_reg(svfa_pkg::CFG_CUTOFF, pick_coeff());
    if ($urandom_range(0, 3) != 0) write_reg(svfa_pkg::CFG_FEEDBACK, pick_coeff());
    if ($urandom_range(0, 3) != 0) write_reg(svfa_pkg::CFG_HPF, pick_hpf());
    if ($urandom_range(0, 3) != 0) write_reg(svfa_pkg::CFG_GAIN, pick_gain());
    if ($urandom_range(0, 9) == 0) begin
      write_reg(3'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)), 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Directed stimulus. A pinned level is typed in where it follows at once from the
  // settings: with zero gain every level is 127, and with the highpass coefficient still
  // zero the highpass store stays zero, so bypass at unity gain gives the clipped half mix
  // plus 127. Unpinned rows are checked against the predictor. Fields that do not apply
  // to a row are left at zero.
  // ---------------------------------------------------------------------------------------
  typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [svfa_pkg::CFG_IDX_W-1:0] idx;
    logic [7:0]                     data;
    logic signed [9:0]              mix;
    logic                           pinned;
    logic [7:0]                     level;
  } script_row_t;

  localparam int SCRIPT_LEN = 37;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // Right after reset the gain is zero.
    '{ROW_SAMPLE, '0,                     '0,    10'sd511,   1'b1, 8'd127},
    '{ROW_SAMPLE, '0,                     '0,    -10'sd512,  1'b1, 8'd127},
    // Unity gain in bypass: clipping at both ends and the floor of the halving.
    '{ROW_WRITE,  svfa_pkg::CFG_GAIN,     8'd128, '0,        1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    10'sd511,   1'b1, 8'd254},
    '{ROW_SAMPLE, '0,                     '0,    -10'sd512,  1'b1, 8'd0},
    '{ROW_SAMPLE, '0,                     '0,    -10'sd1,    1'b1, 8'd126},
    '{ROW_SAMPLE, '0,                     '0,    10'sd1,     1'b1, 8'd127},
    '{ROW_SAMPLE, '0,                     '0,    10'sd254,   1'b1, 8'd254},
    '{ROW_SAMPLE, '0,                     '0,    -10'sd254,  1'b1, 8'd0},
    // The spare mode code behaves as bypass.
    '{ROW_WRITE,  svfa_pkg::CFG_MODE,     8'h03, '0,         1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    -10'sd3,    1'b1, 8'd125},
    // Coefficient extremes; the highpass write drops the top data bit.
    '{ROW_WRITE,  svfa_pkg::CFG_CUTOFF,   8'h80, '0,         1'b0, '0},
    '{ROW_WRITE,  svfa_pkg::CFG_FEEDBACK, 8'h7F, '0,         1'b0, '0},
    '{ROW_WRITE,  svfa_pkg::CFG_HPF,      8'hFF, '0,         1'b0, '0},
    // Writes past the last register are ignored.
    '{ROW_WRITE,  CFG_UNUSED_FIRST,       8'hA5, '0,         1'b0, '0},
    '{ROW_WRITE,  CFG_UNUSED_LAST,        8'h5A, '0,         1'b0, '0},
    // Resonant lowpass, selected with junk in the upper data bits.
    '{ROW_WRITE,  svfa_pkg::CFG_MODE,     8'hFD, '0,         1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    10'sd511,   1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    10'sd511,   1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    -10'sd512,  1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    10'sd381,   1'b0, '0},
    // Rewriting the same mode keeps the filter stores.
    '{ROW_WRITE,  svfa_pkg::CFG_MODE,     8'h01, '0,         1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    -10'sd381,  1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    10'sd0,     1'b0, '0},
    // Two-stage filter with the opposite coefficient extremes and full gain.
    '{ROW_WRITE,  svfa_pkg::CFG_MODE,     8'h02, '0,         1'b0, '0},
    '{ROW_WRITE,  svfa_pkg::CFG_CUTOFF,   8'h7F, '0,         1'b0, '0},
    '{ROW_WRITE,  svfa_pkg::CFG_FEEDBACK, 8'h80, '0,         1'b0, '0},
    '{ROW_WRITE,  svfa_pkg::CFG_HPF,      8'h00, '0,         1'b0, '0},
    '{ROW_WRITE,  svfa_pkg::CFG_GAIN,     8'hFF, '0,         1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    10'sd511,   1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    10'sd511,   1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    -10'sd512,  1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    10'sd100,   1'b0, '0},
    // Back to bypass, then zero gain, which again forces the midpoint.
    '{ROW_WRITE,  svfa_pkg::CFG_MODE,     8'h00, '0,         1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    10'sd2,     1'b0, '0},
    '{ROW_WRITE,  svfa_pkg::CFG_GAIN,     8'h00, '0,         1'b0, '0},
    '{ROW_SAMPLE, '0,                     '0,    10'sd300,   1'b1, 8'd127}
  };

  // ---------------------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------------------
  initial begin
    int  n_random;
    int  phase_len;
    bit  gappy;

    n_random = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers change only once the block has handed back every result.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_WRITE) begin
        if (feeding) quiesce();
        write_reg(SCRIPT[i].idx, SCRIPT[i].data);
      end else begin
        send_mix(SCRIPT[i].mix, SCRIPT[i].pinned, SCRIPT[i].level);
      end
    end

    // Random phases. Most are long enough for the filters to settle into their own
    // behavior; a few are short so that mode changes come often. In some phases the
    // requests arrive back to back, in others with gaps of random length.
    while (n_random < RANDOM_ITEMS) begin
      quiesce();
      retune();
      phase_len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 8) : $urandom_range(20, 90);
      gappy     = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < phase_len; k++) begin
        if (gappy && $urandom_range(0, 2) == 0) begin
          hold_off(($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 4));
        end else if (k != 0 && $urandom_range(0, 299) == 0) begin
          // Now and then the sender waits mid-phase for the block to drain.
          quiesce();
        end
        send_mix(pick_mix(), 1'b0, 8'd0);
      end
      n_random += phase_len;
    end

    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_levels.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_levels.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/svfa_pkg.sv
hdl/svfa_datapath.sv
hdl/synth_voice_filter_amp.sv
hdl/svfa_checker.sv
tb/sv/tb.sv
